### sv/w3f_pkg.sv
// ----------------------------------------------------------------------------
// w3f_pkg: shared types and constants of the 3x3 window image filter
// Payload structs, register indexes, mode codes and the mean reciprocal table.
// ----------------------------------------------------------------------------
package w3f_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] res_red;
    logic [7:0] res_green;
    logic [7:0] res_blue;
    logic       frame_last;
  } out_item_t;

  // Window handed from the front to the back: pixel index is col*3+row.
  typedef struct packed {
    logic [8:0][23:0] pix;
    logic [8:0]       ok;
    logic             last;
  } wnd_item_t;

  typedef struct packed {
    logic [1:0]  filter_mode;
    logic [1:0]  image_kind;
    logic [10:0] image_width;
    logic [15:0] image_height;
  } cfg_regs_t;

  localparam logic [2:0] CFG_FILTER_MODE  = 3'd0;
  localparam logic [2:0] CFG_IMAGE_KIND   = 3'd1;
  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd3;

  localparam logic [1:0] MODE_MEDIAN = 2'd0;
  localparam logic [1:0] MODE_LAPLACE = 2'd1;
  localparam logic [1:0] MODE_MEAN   = 2'd2;
  localparam logic [1:0] MODE_SOBEL  = 2'd3;

  localparam logic [1:0] KIND_BITMAP = 2'd0;
  localparam logic [1:0] KIND_GRAY   = 2'd1;
  localparam logic [1:0] KIND_COLOR  = 2'd2;

  localparam logic ITEM_PIXEL = 1'b0;

  localparam int QDEPTH = 4;
  localparam int RECIP_SHIFT = 16;

  // ceil(2^16 / n); with sums below 2^12 the product shifted down is exact.
  function automatic logic [16:0] recip(input logic [3:0] n);
    logic [16:0] r;
    case (n)
      4'd1: r = 17'd65536;
      4'd2: r = 17'd32768;
      4'd3: r = 17'd21846;
      4'd4: r = 17'd16384;
      4'd5: r = 17'd13108;
      4'd6: r = 17'd10923;
      4'd7: r = 17'd9363;
      4'd8: r = 17'd8192;
      4'd9: r = 17'd7282;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

### sv/window3x3_image_filter.sv
// ----------------------------------------------------------------------------
// window3x3_image_filter: 3x3 window median, Laplacian, mean and Sobel filter
// Top level with the configuration registers, front, queue and back.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in_ channel (valid/ready), one beat per
// pixel or drain tick. Filtered pixels leave on the out_ channel, one per
// pixel of the frame, with frame_last on the last one. A result is due once
// the pixel one row and one column further has arrived; drain ticks after
// the last pixel push out the results still held back.
// Throughput is one beat per clock on both channels as long as out_ready is high.
// A result reaches out_valid once the beat that makes it due has written the
// window queue and has passed through the three registered filter stages.
// The line store is one memory read one beat ahead with a write-to-read
// bypass, so successive beats never wait on it.
// The cfg_ port writes a register; writing the width or height restarts the
// frame. Registers must be written only while idle; the block does not check.
// Reset clears the frame position and empties the queue and pipeline; the
// line stores keep stale data, which never reaches a result.
// When out_ready is low the datapath holds; the four-entry queue absorbs
// beats until it is full, then in_ready drops.
// ----------------------------------------------------------------------------
module window3x3_image_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  w3f_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output w3f_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata
);
  w3f_pkg::cfg_regs_t cfg_r;
  w3f_pkg::wnd_item_t q_in, q_head;
  logic restart, q_push, q_full, q_pop, q_nonempty;

  assign restart = cfg_we && (cfg_addr == w3f_pkg::CFG_IMAGE_WIDTH ||
                              cfg_addr == w3f_pkg::CFG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_mode <= w3f_pkg::MODE_MEDIAN;
      cfg_r.image_kind <= w3f_pkg::KIND_GRAY;
      cfg_r.image_width <= 11'd1024;
      cfg_r.image_height <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        w3f_pkg::CFG_FILTER_MODE:  cfg_r.filter_mode <= cfg_wdata[1:0];
        w3f_pkg::CFG_IMAGE_KIND:   cfg_r.image_kind <= cfg_wdata[1:0];
        w3f_pkg::CFG_IMAGE_WIDTH:  cfg_r.image_width <= cfg_wdata[10:0];
        w3f_pkg::CFG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  w3f_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .restart  (restart),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  w3f_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  w3f_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );
endmodule

### sv/w3f_queue.sv
// ----------------------------------------------------------------------------
// w3f_queue: short window queue
// Holds assembled windows between the front and the back.
// ----------------------------------------------------------------------------
module w3f_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  w3f_pkg::wnd_item_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               nonempty,
  output w3f_pkg::wnd_item_t head
);
  localparam int PW = $clog2(w3f_pkg::QDEPTH);
  localparam int CNTW = $clog2(w3f_pkg::QDEPTH + 1);

  w3f_pkg::wnd_item_t mem_r [w3f_pkg::QDEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CNTW-1:0] cnt_r;

  assign full = (cnt_r == CNTW'(w3f_pkg::QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CNTW'(push) - CNTW'(pop);
    end
  end
endmodule

### sv/w3f_front.sv
// ----------------------------------------------------------------------------
// w3f_front: line stores, window and frame bookkeeping
// Takes pixel and drain beats, shifts the 3x3 window and queues a window
// with its in-frame mask whenever a result becomes due.
// ----------------------------------------------------------------------------
module w3f_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  w3f_pkg::cfg_regs_t  cfg,
  input  logic                restart,
  input  logic                in_valid,
  output logic                in_ready,
  input  w3f_pkg::in_item_t   in_data,
  input  logic                q_full,
  output logic                q_push,
  output w3f_pkg::wnd_item_t  q_data
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int LW = $clog2(MAX_WIDTH + 3);
  localparam int XW = (WW > 11) ? WW : 11;

  logic [47:0] ls_mem [MAX_WIDTH];
  logic [47:0] rd_r, byp_d_r;
  logic        byp_r;

  logic [23:0] win_r [9];
  logic [23:0] win_nxt [9];
  logic [CW-1:0] col_r, col_nxt, scol_r, scol_nxt, oc_r, oc_nxt;
  logic [15:0]   row_r, row_nxt, orow_r, orow_nxt;
  logic [LW-1:0] pend_r, pend_nxt, lag_r, lag_nxt;
  logic          fl_r, fl_nxt;

  logic [XW-1:0] iw_x, w_x;
  logic [WW-1:0] w;
  logic [15:0]   h;
  logic          in_fire, push, emit;
  logic [23:0]   px, up_cur, lo_cur;
  logic [CW-1:0] eoc;
  logic [15:0]   eor;
  logic [2:0]    colok, rowok;

  assign iw_x = XW'(cfg.image_width);
  assign w_x = (iw_x == '0) ? XW'(1) :
               ((iw_x > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : iw_x);
  assign w = WW'(w_x);
  assign h = (cfg.image_height == '0) ? 16'd1 : cfg.image_height;

  assign in_ready = !q_full;
  assign in_fire = in_valid && in_ready;
  assign up_cur = byp_r ? byp_d_r[47:24] : rd_r[47:24];
  assign lo_cur = byp_r ? byp_d_r[23:0] : rd_r[23:0];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    scol_nxt = scol_r;
    oc_nxt = oc_r;
    orow_nxt = orow_r;
    pend_nxt = pend_r;
    lag_nxt = lag_r;
    fl_nxt = fl_r;
    push = 1'b0;
    emit = 1'b0;
    px = '0;
    eoc = '0;
    eor = '0;
    for (int i = 0; i < 9; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
      scol_nxt = '0;
      oc_nxt = '0;
      orow_nxt = '0;
      pend_nxt = '0;
      lag_nxt = '0;
      fl_nxt = 1'b0;
    end else if (in_fire) begin
      if (in_data.kind == w3f_pkg::ITEM_PIXEL) begin
        // A pixel during a flush drops what is left and opens a new frame.
        if (fl_r) begin
          pend_nxt = '0;
          lag_nxt = '0;
          oc_nxt = '0;
          orow_nxt = '0;
          fl_nxt = 1'b0;
        end
        push = 1'b1;
        px = {in_data.pix_red, in_data.pix_green, in_data.pix_blue};
        pend_nxt = pend_nxt + 1'b1;
        lag_nxt = lag_nxt + 1'b1;
        if (WW'(col_r) + 1'b1 >= w) begin
          col_nxt = '0;
          row_nxt = (17'(row_r) + 17'd1 >= 17'(h)) ? '0 : row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end else if (pend_r != '0 && col_r == '0 && row_r == '0) begin
        push = 1'b1;
        fl_nxt = 1'b1;
        lag_nxt = lag_nxt + 1'b1;
      end
      if (push) begin
        for (int i = 0; i < 6; i++) begin
          win_nxt[i] = win_r[i+3];
        end
        win_nxt[6] = up_cur;
        win_nxt[7] = lo_cur;
        win_nxt[8] = px;
        scol_nxt = (WW'(scol_r) + 1'b1 >= w) ? '0 : scol_r + 1'b1;
        emit = (lag_nxt > LW'(w) + 1'b1);
      end
      if (emit) begin
        eoc = oc_nxt;
        eor = orow_nxt;
        if (WW'(oc_nxt) + 1'b1 >= w) begin
          oc_nxt = '0;
          orow_nxt = (17'(orow_nxt) + 17'd1 >= 17'(h)) ? '0 : orow_nxt + 1'b1;
        end else begin
          oc_nxt = oc_nxt + 1'b1;
        end
        pend_nxt = pend_nxt - 1'b1;
        lag_nxt = lag_nxt - 1'b1;
        if (in_data.kind != w3f_pkg::ITEM_PIXEL && pend_nxt == '0) begin
          lag_nxt = '0;
          fl_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    colok = {WW'(eoc) + 1'b1 < w, 1'b1, eoc != '0};
    rowok = {17'(eor) + 17'd1 < 17'(h), 1'b1, eor != '0};
    for (int q = 0; q < 3; q++) begin
      for (int r = 0; r < 3; r++) begin
        q_data.ok[q*3+r] = colok[q] && rowok[r];
      end
    end
    for (int i = 0; i < 9; i++) begin
      q_data.pix[i] = win_nxt[i];
    end
    q_data.last = !colok[2] && !rowok[2];
  end

  assign q_push = emit;

  // The line store is read one beat ahead at the column the next push uses.
  always_ff @(posedge clk) begin
    if (push) begin
      ls_mem[scol_r] <= {lo_cur, px};
    end
    rd_r <= ls_mem[scol_nxt];
    byp_d_r <= {lo_cur, px};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
      col_r <= '0;
      row_r <= '0;
      scol_r <= '0;
      oc_r <= '0;
      orow_r <= '0;
      pend_r <= '0;
      lag_r <= '0;
      fl_r <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      byp_r <= push && (scol_nxt == scol_r);
      col_r <= col_nxt;
      row_r <= row_nxt;
      scol_r <= scol_nxt;
      oc_r <= oc_nxt;
      orow_r <= orow_nxt;
      pend_r <= pend_nxt;
      lag_r <= lag_nxt;
      fl_r <= fl_nxt;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  a_lag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lag_r <= LW'(w) + 1'b1)
    else $error("lag count beyond one row and a pixel");
  a_pend_le_lag: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= lag_r)
    else $error("more pending pixels than beats in the lag");
  a_scol_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(scol_r) < w)
    else $error("line store column outside the row");
endmodule

### sv/w3f_back.sv
// ----------------------------------------------------------------------------
// w3f_back: filter datapath
// Three stages: ranks and sums, selection and mean product, final choice.
// ----------------------------------------------------------------------------
module w3f_back (
  input  logic               clk,
  input  logic               rst_n,
  input  w3f_pkg::cfg_regs_t cfg,
  input  logic               q_nonempty,
  input  w3f_pkg::wnd_item_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output w3f_pkg::out_item_t out_data
);
  logic en;
  logic v1_r, v2_r, ov_r;

  logic [7:0]  val [3][9];
  logic [3:0]  rank [3][9];
  logic [3:0]  n;
  logic [11:0] sum [3];
  logic signed [11:0] lap [3], gx [3], gy [3];

  logic [7:0]  val1_r [3][9];
  logic [3:0]  rank1_r [3][9];
  logic [8:0]  ok1_r;
  logic [3:0]  n1_r;
  logic [11:0] sum1_r [3];
  logic signed [11:0] lap1_r [3], gx1_r [3], gy1_r [3];
  logic [23:0] ctr1_r, ctr2_r;
  logic        last1_r, last2_r;

  logic [7:0]  med [3], lapc [3], sobc [3];
  logic [12:0] sob_abs [3];
  logic [7:0]  med2_r [3], lap2_r [3], sob2_r [3];
  logic [28:0] prod2_r [3];
  logic [7:0]  fin [3];
  w3f_pkg::out_item_t out_nxt, out_r;

  assign en = !ov_r || out_ready;
  assign q_pop = q_nonempty && en;
  assign out_valid = ov_r;
  assign out_data = out_r;

  // Stage one: per-channel masked values, ranks, sums and gradients.
  always_comb begin
    n = '0;
    for (int i = 0; i < 9; i++) begin
      n = n + 4'(q_head.ok[i]);
    end
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 9; i++) begin
        val[c][i] = q_head.ok[i] ? q_head.pix[i][(2-c)*8 +: 8] : 8'd0;
      end
      // Ties are broken by position, so valid entries get distinct ranks.
      for (int i = 0; i < 9; i++) begin
        rank[c][i] = '0;
        for (int j = 0; j < 9; j++) begin
          if (j != i && q_head.ok[j] &&
              (val[c][j] < val[c][i] || (val[c][j] == val[c][i] && j < i))) begin
            rank[c][i] = rank[c][i] + 1'b1;
          end
        end
      end
      sum[c] = '0;
      for (int i = 0; i < 9; i++) begin
        sum[c] = sum[c] + 12'(val[c][i]);
      end
      lap[c] = $signed({4'd0, val[c][3]}) + $signed({4'd0, val[c][1]})
             + $signed({4'd0, val[c][7]}) + $signed({4'd0, val[c][5]})
             - $signed({2'd0, val[c][4], 2'd0});
      gy[c] = $signed({4'd0, val[c][2]}) + $signed({3'd0, val[c][5], 1'b0})
            + $signed({4'd0, val[c][8]}) - $signed({4'd0, val[c][0]})
            - $signed({3'd0, val[c][3], 1'b0}) - $signed({4'd0, val[c][6]});
      gx[c] = $signed({4'd0, val[c][6]}) + $signed({3'd0, val[c][7], 1'b0})
            + $signed({4'd0, val[c][8]}) - $signed({4'd0, val[c][0]})
            - $signed({3'd0, val[c][1], 1'b0}) - $signed({4'd0, val[c][2]});
    end
  end

  // Stage two inputs: median pick and clamps.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      med[c] = '0;
      for (int i = 0; i < 9; i++) begin
        if (ok1_r[i] && rank1_r[c][i] == (n1_r >> 1)) begin
          med[c] = val1_r[c][i];
        end
      end
      if (lap1_r[c] < 0) begin
        lapc[c] = '0;
      end else if (lap1_r[c] > 12'sd255) begin
        lapc[c] = 8'd255;
      end else begin
        lapc[c] = lap1_r[c][7:0];
      end
      sob_abs[c] = 13'(gx1_r[c] < 0 ? -gx1_r[c] : gx1_r[c])
                 + 13'(gy1_r[c] < 0 ? -gy1_r[c] : gy1_r[c]);
      sobc[c] = (sob_abs[c] > 13'd255) ? 8'd255 : sob_abs[c][7:0];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (cfg.filter_mode)
        w3f_pkg::MODE_MEDIAN:  fin[c] = med2_r[c];
        w3f_pkg::MODE_LAPLACE: fin[c] = lap2_r[c];
        w3f_pkg::MODE_MEAN:    fin[c] = prod2_r[c][w3f_pkg::RECIP_SHIFT +: 8];
        default:               fin[c] = sob2_r[c];
      endcase
    end
    out_nxt.frame_last = last2_r;
    case (cfg.image_kind)
      w3f_pkg::KIND_GRAY: begin
        out_nxt.res_red = fin[0];
        out_nxt.res_green = '0;
        out_nxt.res_blue = '0;
      end
      w3f_pkg::KIND_COLOR: begin
        out_nxt.res_red = fin[0];
        out_nxt.res_green = fin[1];
        out_nxt.res_blue = fin[2];
      end
      default: begin
        out_nxt.res_red = ctr2_r[23:16];
        out_nxt.res_green = ctr2_r[15:8];
        out_nxt.res_blue = ctr2_r[7:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val1_r <= val;
      rank1_r <= rank;
      ok1_r <= q_head.ok;
      n1_r <= n;
      sum1_r <= sum;
      lap1_r <= lap;
      gx1_r <= gx;
      gy1_r <= gy;
      ctr1_r <= q_head.pix[4];
      last1_r <= q_head.last;
      for (int c = 0; c < 3; c++) begin
        med2_r[c] <= med[c];
        lap2_r[c] <= lapc[c];
        sob2_r[c] <= sobc[c];
        prod2_r[c] <= 29'(sum1_r[c]) * 29'(w3f_pkg::recip(n1_r));
      end
      ctr2_r <= ctr1_r;
      last2_r <= last1_r;
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      v1_r <= q_nonempty;
      v2_r <= v1_r;
      ov_r <= v2_r;
    end
  end
endmodule
